/* hdl/free_explore_drive_fsm_defines.svh */
// Assertion macros used by the checker file of the exploration drive block.
`ifndef FREE_EXPLORE_DRIVE_FSM_DEFINES_SVH
`define FREE_EXPLORE_DRIVE_FSM_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define FEDF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fedf assertion failed");

// Property checked at every clock edge, reset included.
`define FEDF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fedf assertion failed");

`endif

/* hdl/fedf_pkg.sv */
// Types, constants and reset values of the exploration drive block.
`default_nettype none
package fedf_pkg;

   localparam int RANGE_W     = 16;
   localparam int SPEED_W     = 15;
   localparam int DRIVE_W     = 16;
   localparam int PHASE_W     = 3;
   localparam int MODE_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;

   localparam int unsigned CRUISE_SPEED_INIT = 2048;

   typedef enum logic [PHASE_W-1:0] {
      PH_FORWARD    = 3'd0,
      PH_LEFT       = 3'd1,
      PH_RIGHT      = 3'd2,
      PH_CRIT_LEFT  = 3'd3,
      PH_CRIT_RIGHT = 3'd4
   } fedf_phase_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_EXPLORE = 2'd0,
      MODE_STOP    = 2'd1,
      MODE_FASTER  = 2'd2,
      MODE_SLOWER  = 2'd3
   } fedf_mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_CLEAR_AHEAD = 3'd0,
      CSR_MIN_SIDE_CLEAR  = 3'd1,
      CSR_CRITICAL_SIDE   = 3'd2,
      CSR_HYST_NORMAL     = 3'd3,
      CSR_HYST_CRITICAL   = 3'd4,
      CSR_SPEED_STEP      = 3'd5,
      CSR_MAX_SPEED       = 3'd6,
      CSR_MIN_SPEED       = 3'd7
   } fedf_csr_type;

   typedef struct packed {
      logic [RANGE_W-1:0] min_clear_ahead;
      logic [RANGE_W-1:0] min_side_clear;
      logic [RANGE_W-1:0] critical_side;
      logic [RANGE_W-1:0] hyst_normal;
      logic [RANGE_W-1:0] hyst_critical;
      logic [SPEED_W-1:0] speed_step;
      logic [SPEED_W-1:0] max_speed;
      logic [SPEED_W-1:0] min_speed;
   } fedf_cfg_type;

   localparam fedf_cfg_type CFG_RESET = '{
      min_clear_ahead: 16'd1229,
      min_side_clear:  16'd1434,
      critical_side:   16'd819,
      hyst_normal:     16'd102,
      hyst_critical:   16'd2048,
      speed_step:      15'd410,
      max_speed:       15'd4096,
      min_speed:       15'd410
   };

   typedef struct packed {
      fedf_phase_type     phase;
      logic [SPEED_W-1:0] cruise;
   } fedf_state_type;

   typedef struct packed {
      fedf_mode_type      mode;
      logic [RANGE_W-1:0] center_range;
      logic [RANGE_W-1:0] left_range;
      logic [RANGE_W-1:0] right_range;
   } fedf_item_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic [PHASE_W-1:0]        explore_phase;
   } fedf_result_type;

endpackage
`default_nettype wire

/* hdl/fedf_step.sv */
// One control step: wheel drive, phase transition and cruise speed update.
`default_nettype none
module fedf_step (
   input  fedf_pkg::fedf_cfg_type    cfg,
   input  fedf_pkg::fedf_state_type  cur,
   input  fedf_pkg::fedf_item_type   item,
   output fedf_pkg::fedf_state_type  nxt,
   output fedf_pkg::fedf_result_type res
);

   logic [fedf_pkg::DRIVE_W-1:0]   s16;
   logic [fedf_pkg::DRIVE_W-1:0]   h16;
   logic [fedf_pkg::RANGE_W:0]     clear_norm;
   logic [fedf_pkg::RANGE_W:0]     clear_crit;
   logic [fedf_pkg::RANGE_W:0]     side_exit;
   logic [fedf_pkg::RANGE_W:0]     c17;
   logic [fedf_pkg::RANGE_W:0]     l17;
   logic [fedf_pkg::RANGE_W:0]     r17;
   logic                           near_c;
   logic [fedf_pkg::SPEED_W:0]     faster_sum;
   logic [fedf_pkg::SPEED_W-1:0]   faster_spd;
   logic [fedf_pkg::SPEED_W-1:0]   slower_diff;
   logic [fedf_pkg::SPEED_W-1:0]   slower_clamp;
   logic [fedf_pkg::SPEED_W-1:0]   slower_spd;
   logic [fedf_pkg::DRIVE_W-1:0]   new_s16;

   assign s16 = {1'b0, cur.cruise};
   assign h16 = {2'b00, cur.cruise[fedf_pkg::SPEED_W-1:1]};

   // Threshold sums are exact in 17 bits
   assign clear_norm = {1'b0, cfg.min_clear_ahead} + {1'b0, cfg.hyst_normal};
   assign clear_crit = {1'b0, cfg.min_clear_ahead} + {1'b0, cfg.hyst_critical};
   assign side_exit  = {1'b0, cfg.critical_side} + {1'b0, cfg.hyst_critical};
   assign c17 = {1'b0, item.center_range};
   assign l17 = {1'b0, item.left_range};
   assign r17 = {1'b0, item.right_range};
   assign near_c = item.center_range < cfg.min_clear_ahead;

   assign faster_sum = {1'b0, cur.cruise} + {1'b0, cfg.speed_step};
   assign faster_spd = (faster_sum >= {1'b0, cfg.max_speed}) ? cfg.max_speed
                                                             : faster_sum[fedf_pkg::SPEED_W-1:0];

   assign slower_diff  = (cur.cruise < cfg.speed_step) ? '0 : cur.cruise - cfg.speed_step;
   assign slower_clamp = (slower_diff >= cfg.max_speed) ? cfg.max_speed : slower_diff;
   // min wins over max
   assign slower_spd   = (slower_clamp < cfg.min_speed) ? cfg.min_speed : slower_clamp;

   always_comb begin
      nxt             = cur;
      res.left_drive  = '0;
      res.right_drive = '0;
      new_s16         = '0;
      unique case (item.mode)
         fedf_pkg::MODE_EXPLORE: begin
            // later test overrides the earlier one
            unique case (cur.phase)
               fedf_pkg::PH_LEFT: begin
                  res.right_drive = 16'd0 - h16;
                  if (item.right_range < cfg.critical_side) nxt.phase = fedf_pkg::PH_CRIT_LEFT;
                  if (c17 > clear_norm) nxt.phase = fedf_pkg::PH_FORWARD;
               end
               fedf_pkg::PH_RIGHT: begin
                  res.left_drive = h16;
                  if (item.left_range < cfg.critical_side) nxt.phase = fedf_pkg::PH_CRIT_RIGHT;
                  if (c17 > clear_norm) nxt.phase = fedf_pkg::PH_FORWARD;
               end
               fedf_pkg::PH_CRIT_LEFT: begin
                  res.left_drive  = 16'd0 - h16;
                  res.right_drive = 16'd0 - h16;
                  if (r17 > side_exit) nxt.phase = fedf_pkg::PH_LEFT;
                  if (c17 > clear_crit) nxt.phase = fedf_pkg::PH_FORWARD;
               end
               fedf_pkg::PH_CRIT_RIGHT: begin
                  res.left_drive  = h16;
                  res.right_drive = h16;
                  if (l17 > side_exit) nxt.phase = fedf_pkg::PH_RIGHT;
                  if (c17 > clear_crit) nxt.phase = fedf_pkg::PH_FORWARD;
               end
               default: begin
                  nxt.phase       = fedf_pkg::PH_FORWARD;
                  res.left_drive  = s16;
                  res.right_drive = 16'd0 - s16;
                  if ((near_c && (item.right_range < item.left_range)) ||
                      (item.right_range < cfg.min_side_clear)) begin
                     nxt.phase = fedf_pkg::PH_LEFT;
                  end
                  if ((near_c && (item.left_range < item.right_range)) ||
                      (item.left_range < cfg.min_side_clear)) begin
                     nxt.phase = fedf_pkg::PH_RIGHT;
                  end
               end
            endcase
         end
         fedf_pkg::MODE_STOP: begin
            res.left_drive  = '0;
            res.right_drive = '0;
         end
         fedf_pkg::MODE_FASTER, fedf_pkg::MODE_SLOWER: begin
            nxt.cruise = (item.mode == fedf_pkg::MODE_FASTER) ? faster_spd : slower_spd;
            new_s16 = {1'b0, nxt.cruise};
            res.left_drive  = new_s16;
            res.right_drive = 16'd0 - new_s16;
         end
      endcase
      res.explore_phase = nxt.phase;
   end

endmodule
`default_nettype wire

/* hdl/free_explore_drive_fsm.sv */
// Top level of the exploration drive controller: channels, registers and state.
//
// Usage:
//  - req_ channel carries one sensor transaction: mode plus center, left and
//    right ranges. Each accepted transaction yields exactly one rsp_ transaction
//    with both wheel drives and the exploration phase after the step.
//  - csr_ port writes the eight thresholds and speed settings; write only
//    while no transaction is in flight.
//  - Pipeline: an accepted transaction passes one input register, then the
//    step logic into the result register, whose valid flag drives
//    rsp_tvalid.
//  - Throughput is one transaction per cycle while rsp_tready stays high; the
//    phase and cruise speed feedback resolves inside the single step stage.
//  - When the receiver holds rsp_tready low, the result register holds and
//    one more transaction waits in the input register; req_tready then drops.
//  - Synchronous reset empties both stages, restores the register defaults,
//    sets the phase to forward and the cruise speed to CRUISE_SPEED_INIT.
`default_nettype none
module free_explore_drive_fsm #(
   parameter int unsigned CRUISE_SPEED_INIT = fedf_pkg::CRUISE_SPEED_INIT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // mode[1:0], center_range[17:2], left_range[33:18], right_range[49:34]
   input  wire logic [fedf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // left_drive[15:0], right_drive[31:16], explore_phase[34:32]
   output logic [fedf_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [fedf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [fedf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   fedf_pkg::fedf_cfg_type    cfg_ff, cfg_in;
   fedf_pkg::fedf_state_type  state_ff, state_in;
   fedf_pkg::fedf_item_type   item_ff, item_in;
   fedf_pkg::fedf_result_type result_ff, result_in;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   fedf_pkg::fedf_state_type  step_nxt;
   fedf_pkg::fedf_result_type step_res;
   logic                      out_free;
   logic                      s1_adv;
   logic                      req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (fedf_pkg::fedf_csr_type'(csr_addr))
            fedf_pkg::CSR_MIN_CLEAR_AHEAD: cfg_in.min_clear_ahead = csr_wdata;
            fedf_pkg::CSR_MIN_SIDE_CLEAR:  cfg_in.min_side_clear  = csr_wdata;
            fedf_pkg::CSR_CRITICAL_SIDE:   cfg_in.critical_side   = csr_wdata;
            fedf_pkg::CSR_HYST_NORMAL:     cfg_in.hyst_normal     = csr_wdata;
            fedf_pkg::CSR_HYST_CRITICAL:   cfg_in.hyst_critical   = csr_wdata;
            fedf_pkg::CSR_SPEED_STEP:
               cfg_in.speed_step = csr_wdata[fedf_pkg::SPEED_W-1:0];
            fedf_pkg::CSR_MAX_SPEED:
               cfg_in.max_speed  = csr_wdata[fedf_pkg::SPEED_W-1:0];
            fedf_pkg::CSR_MIN_SPEED:
               cfg_in.min_speed  = csr_wdata[fedf_pkg::SPEED_W-1:0];
         endcase
      end
   end

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.mode         = fedf_pkg::fedf_mode_type'(req_tdata[1:0]);
         item_in.center_range = req_tdata[17:2];
         item_in.left_range   = req_tdata[33:18];
         item_in.right_range  = req_tdata[49:34];
      end
   end

   fedf_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (step_nxt),
      .res  (step_res)
   );

   // Advance state and result only when the input stage moves forward
   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !out_free);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);
      state_in     = s1_adv ? step_nxt : state_ff;
      result_in    = s1_adv ? step_res : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= fedf_pkg::CFG_RESET;
         state_ff.phase  <= fedf_pkg::PH_FORWARD;
         state_ff.cruise <= fedf_pkg::SPEED_W'(CRUISE_SPEED_INIT);
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, result_ff.explore_phase,
                        result_ff.right_drive, result_ff.left_drive};

endmodule
`default_nettype wire

/* hdl/fedf_checker.sv */
// Port-level checker for the exploration drive block, bound to the top level.
`default_nettype none
`include "free_explore_drive_fsm_defines.svh"
module fedf_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [fedf_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [fedf_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_seen;
   logic req_mode_ok;

   assign req_seen    = req_tvalid && req_tready;
   assign req_mode_ok = req_tdata[1:0] == req_tdata[1:0];

   // Stalled result holds its payload
   `FEDF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // Reset empties the result stage
   `FEDF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // Reported phase is one of the five exploration phases
   `FEDF_ASSERT(a_phase_range, clock, reset, rsp_tvalid |-> rsp_tdata[34:32] <= 3'd4 && rsp_tdata[39:35] == 5'd0)

   // A result from an empty pipe comes from a transaction accepted into the input register before it
   `FEDF_ASSERT(a_rise_latency, clock, reset, $rose(rsp_tvalid) |-> $past(req_seen && req_mode_ok, 2))

endmodule

bind free_explore_drive_fsm fedf_checker u_fedf_checker (.*);
`default_nettype wire
